// File: design/mxt_pkg.sv
package mxt_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int KEY_BITS   = 32;
  localparam int FIELD_W    = 32;

  // node index into the pool, and a link wide enough to hold NODE_COUNT itself
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int LINK_W = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(KEY_BITS + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [LINK_W-1:0] link1;
    logic [LINK_W-1:0] link0;
  } link_pair_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    link_pair_t        wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: design/mxt_node_ram.sv
module mxt_node_ram (
  input  logic                clk,
  input  mxt_pkg::ram_req_t   req,
  output mxt_pkg::link_pair_t rdata
);

  mxt_pkg::link_pair_t mem [mxt_pkg::NODE_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: design/max_xor_pair_trie.sv
// Maximum-XOR search over a binary trie of 32-bit keys. An insert word adds
// its key, a query word returns the largest XOR of its key with any stored
// key plus the running maximum over all queries, a clear word empties both.
// Inserts and queries walk one trie level per cycle, since each level needs
// one registered read of the node RAM. Clear, a refused insert and a query
// on an empty store skip the walk. The result register frees the input side
// while a finished result waits to be taken. The node RAM needs no clearing
// pass; the root links live in flops and each node is written when allocated.
module max_xor_pair_trie (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  action,
  input  logic [31:0] key_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] best_xor,
  output logic [31:0] running_max,
  output logic        set_empty,
  output logic        store_full
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t                          state;
  logic [1:0]                      op;
  logic [mxt_pkg::KEY_BITS-1:0]    key_sr;
  logic [mxt_pkg::KEY_BITS-1:0]    acc;
  logic [mxt_pkg::LVL_W-1:0]       lvl;
  logic [mxt_pkg::NODE_W-1:0]      node;
  logic                            at_root;
  logic                            fresh;
  logic                            stopped;
  logic                            res_empty;
  logic                            res_full;
  mxt_pkg::link_pair_t             root;
  logic [mxt_pkg::LINK_W-1:0]      nf;
  logic [mxt_pkg::FIELD_W-1:0]     max_so_far;

  mxt_pkg::ram_req_t               req;
  mxt_pkg::link_pair_t             rd_data;

  mxt_pkg::link_pair_t             cur;
  mxt_pkg::link_pair_t             upd;
  logic                            b;
  logic [mxt_pkg::LINK_W-1:0]      same;
  logic [mxt_pkg::LINK_W-1:0]      opp;
  logic                            alloc;
  logic [mxt_pkg::LINK_W-1:0]      nxt;
  logic                            acc_bit;
  logic                            stop_next;
  logic                            out_free;
  logic                            full_now;
  logic [mxt_pkg::FIELD_W-1:0]     best32;
  logic [mxt_pkg::FIELD_W-1:0]     max_next;
  logic [mxt_pkg::KEY_BITS+mxt_pkg::FIELD_W-1:0] key_ext;
  logic [mxt_pkg::KEY_BITS+mxt_pkg::FIELD_W-1:0] acc_ext;

  mxt_node_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rd_data)
  );

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign key_ext    = {{mxt_pkg::KEY_BITS{1'b0}}, key_value};
  assign acc_ext    = {{mxt_pkg::FIELD_W{1'b0}}, acc};
  assign best32     = acc_ext[mxt_pkg::FIELD_W-1:0];
  assign full_now   = nf > mxt_pkg::LINK_W'(mxt_pkg::NODE_COUNT - mxt_pkg::KEY_BITS);

  always_comb begin
    b = key_sr[mxt_pkg::KEY_BITS-1];
    // nodes allocated on this walk are known empty, so skip the RAM data
    if (at_root) begin
      cur = root;
    end else if (fresh) begin
      cur = '0;
    end else begin
      cur = rd_data;
    end
    same = b ? cur.link1 : cur.link0;
    opp  = b ? cur.link0 : cur.link1;

    alloc     = 1'b0;
    nxt       = same;
    acc_bit   = 1'b0;
    stop_next = stopped;
    upd       = cur;
    if (op == mxt_pkg::ACT_INSERT) begin
      alloc = (same == '0);
      if (alloc) begin
        nxt = nf;
        if (b) begin
          upd.link1 = nf;
        end else begin
          upd.link0 = nf;
        end
      end
    end else if (!stopped) begin
      if (opp != '0) begin
        acc_bit = 1'b1;
        nxt     = opp;
      end else if (same == '0) begin
        stop_next = 1'b1;
      end
    end

    req.raddr = nxt[mxt_pkg::NODE_W-1:0];
    req.waddr = node;
    req.we    = 1'b0;
    req.wdata = upd;
    if (state == S_WALK && op == mxt_pkg::ACT_INSERT && alloc && !at_root) begin
      req.we = 1'b1;
    end else if (state == S_FINISH && op == mxt_pkg::ACT_INSERT && fresh && out_free) begin
      // leaf of a new path
      req.we    = 1'b1;
      req.wdata = '0;
    end

    max_next = max_so_far;
    if (op == mxt_pkg::ACT_CLEAR) begin
      max_next = '0;
    end else if (op == mxt_pkg::ACT_QUERY && !res_empty && best32 > max_so_far) begin
      max_next = best32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      root         <= '0;
      nf           <= mxt_pkg::LINK_W'(1);
      max_so_far   <= '0;
    end else begin
      // a finishing word reloads the result register in the same cycle
      if (result_valid && result_ready && state != S_FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op        <= action;
            key_sr    <= key_ext[mxt_pkg::KEY_BITS-1:0];
            acc       <= '0;
            lvl       <= mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
            node      <= '0;
            at_root   <= 1'b1;
            fresh     <= 1'b0;
            stopped   <= 1'b0;
            res_empty <= (action == mxt_pkg::ACT_QUERY) &&
                         root.link0 == '0 && root.link1 == '0;
            res_full  <= (action == mxt_pkg::ACT_INSERT) && full_now;
            if ((action == mxt_pkg::ACT_INSERT && !full_now) ||
                (action == mxt_pkg::ACT_QUERY &&
                 (root.link0 != '0 || root.link1 != '0))) begin
              state <= S_WALK;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_WALK: begin
          if (at_root && op == mxt_pkg::ACT_INSERT) begin
            root <= upd;
          end
          if (alloc) begin
            nf <= nf + mxt_pkg::LINK_W'(1);
          end
          fresh   <= alloc;
          stopped <= stop_next;
          at_root <= 1'b0;
          node    <= nxt[mxt_pkg::NODE_W-1:0];
          key_sr  <= mxt_pkg::KEY_BITS'({key_sr, 1'b0});
          acc     <= mxt_pkg::KEY_BITS'({acc, acc_bit});
          lvl     <= lvl - mxt_pkg::LVL_W'(1);
          if (lvl == '0) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (op == mxt_pkg::ACT_CLEAR) begin
              root <= '0;
              nf   <= mxt_pkg::LINK_W'(1);
            end
            max_so_far   <= max_next;
            result_valid <= 1'b1;
            best_xor     <= best32;
            running_max  <= max_next;
            set_empty    <= res_empty;
            store_full   <= res_full;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
